@@ rtl/bgrd_pkg.sv @@
// ----------------------------------------------------------------------------
// bgrd_pkg: shared types for the button grid release debouncer
// Configuration constants and the flag group that the update logic returns.
// ----------------------------------------------------------------------------
package bgrd_pkg;

    localparam int unsigned CFG_W = 8;
    localparam logic [CFG_W-1:0] CFG_RESET = 8'd8;

    typedef logic [CFG_W-1:0] t_cfg;

    // Flags from the per-button update to the store and result logic.
    typedef struct packed {
        logic wr;
        logic change;
    } t_upd;

endpackage

@@ rtl/bgrd_ram.sv @@
// ----------------------------------------------------------------------------
// bgrd_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module bgrd_ram #(
    parameter int unsigned WIDTH  = 9,
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bgrd_update.sv @@
// ----------------------------------------------------------------------------
// bgrd_update: per-button debounce decision
// Accepts a fresh press at once and counts stable scans before a release.
// ----------------------------------------------------------------------------
module bgrd_update #(
    parameter int unsigned COUNTER_BITS = 8
) (
    input  logic                    i_raw,
    input  logic                    i_prev,
    input  logic                    i_settled,
    input  logic [COUNTER_BITS-1:0] i_count,
    input  bgrd_pkg::t_cfg          i_cfg,
    output logic                    o_level,
    output logic [COUNTER_BITS-1:0] o_count,
    output bgrd_pkg::t_upd          o_upd
);
    import bgrd_pkg::*;

    logic                    fresh;
    logic                    differs;
    logic [COUNTER_BITS-1:0] dec;

    assign fresh   = i_raw != i_prev;
    assign differs = i_raw != i_settled;
    assign dec     = i_count - COUNTER_BITS'(1);

    always_comb begin
        o_level      = i_settled;
        o_count      = i_count;
        o_upd.wr     = 1'b1;
        o_upd.change = 1'b0;
        if (fresh && differs) begin
            if (i_raw) begin
                o_level      = 1'b1;
                o_upd.change = 1'b1;
            end else begin
                o_count = COUNTER_BITS'(i_cfg);
            end
        end else if (!fresh && differs && (i_count != '0)) begin
            // A stable level that still differs counts down toward acceptance.
            o_count = dec;
            if (dec == '0) begin
                o_level      = i_raw;
                o_upd.change = 1'b1;
            end
        end
    end

endmodule

@@ rtl/button_grid_release_debouncer.sv @@
// ----------------------------------------------------------------------------
// button_grid_release_debouncer: asymmetric debounce for a button grid
// An accepted beat is registered into stage 1 with the store read, then into
// the output register. Throughput: one beat per cycle while the sink does not stall;
// the per-button RAM store is read at accept and written back from stage 1, with a one-entry bypass.
// Reset (synchronous, active low) clears all per-entry valid bits at once,
// so every button reads as released with a zero counter; the count is 8.
// ----------------------------------------------------------------------------
module button_grid_release_debouncer #(
    parameter int unsigned ROW_COUNT    = 32,
    parameter int unsigned COLUMN_COUNT = 8,
    parameter int unsigned COUNTER_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  bgrd_pkg::t_cfg i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [4:0]     i_grid_row,
    input  logic [2:0]     i_grid_column,
    input  logic           i_raw_level,
    input  logic           i_previous_level,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_change_event,
    output logic           o_debounced_level
);
    import bgrd_pkg::*;

    localparam int unsigned DEPTH   = ROW_COUNT * COLUMN_COUNT;
    localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned ENTRY_W = COUNTER_BITS + 1;

    t_cfg r_cfg;

    logic                    en;
    logic                    in_grid;
    logic [ADDR_W-1:0]       in_addr;

    logic                    r_s1_valid;
    logic                    r_s1_grid;
    logic [ADDR_W-1:0]       r_s1_addr;
    logic                    r_s1_raw;
    logic                    r_s1_prev;

    logic [ENTRY_W-1:0]      rd_entry;
    logic [ENTRY_W-1:0]      cur_entry;
    logic [ENTRY_W-1:0]      new_entry;
    logic                    new_level;
    logic [COUNTER_BITS-1:0] new_count;
    t_upd                    upd;
    logic                    wr;

    logic                    r_vld [DEPTH];
    logic                    r_fwd_valid;
    logic [ADDR_W-1:0]       r_fwd_addr;
    logic [ENTRY_W-1:0]      r_fwd_data;

    logic                    r_out_valid;
    logic                    r_change;
    logic                    r_level;

    // The whole pipe advances unless a finished result is held by the sink.
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    assign in_grid = (32'(i_grid_row) < ROW_COUNT) && (32'(i_grid_column) < COLUMN_COUNT);
    assign in_addr = in_grid
                   ? ADDR_W'(32'(i_grid_row) * COLUMN_COUNT + 32'(i_grid_column))
                   : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_grid <= in_grid;
            r_s1_addr <= in_addr;
            r_s1_raw  <= i_raw_level;
            r_s1_prev <= i_previous_level;
        end
    end

    bgrd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr),
        .i_waddr(r_s1_addr),
        .i_wdata(new_entry),
        .i_re   (en),
        .i_raddr(in_addr),
        .o_rdata(rd_entry)
    );

    // The write of the previous beat lands at the same edge as this beat's
    // read, so that entry is taken from the bypass register instead.
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            cur_entry = r_fwd_data;
        end else if (r_vld[r_s1_addr]) begin
            cur_entry = rd_entry;
        end else begin
            cur_entry = '0;
        end
    end

    bgrd_update #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_update (
        .i_raw    (r_s1_raw),
        .i_prev   (r_s1_prev),
        .i_settled(cur_entry[COUNTER_BITS]),
        .i_count  (cur_entry[COUNTER_BITS-1:0]),
        .i_cfg    (r_cfg),
        .o_level  (new_level),
        .o_count  (new_count),
        .o_upd    (upd)
    );

    assign new_entry = {new_level, new_count};
    assign wr        = en && r_s1_valid && r_s1_grid && upd.wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(DEPTH); i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (wr) begin
            r_vld[r_s1_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (en) begin
            r_fwd_valid <= wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_change <= r_s1_grid && upd.change;
            r_level  <= r_s1_grid && new_level;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_change_event    = r_change;
    assign o_debounced_level = r_level;

endmodule

@@ rtl/bgrd_checker.sv @@
// ----------------------------------------------------------------------------
// bgrd_checker: port-level checks for the button grid release debouncer
// Watches the top-level ports over time; attached to the top by bind.
// ----------------------------------------------------------------------------
module bgrd_checker #(
    parameter int unsigned ROW_COUNT    = 32,
    parameter int unsigned COLUMN_COUNT = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [4:0] i_grid_row,
    input logic [2:0] i_grid_column,
    input logic       i_raw_level,
    input logic       i_previous_level,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_change_event,
    input logic       o_debounced_level
);

    logic accept;
    logic off_grid;

    assign accept   = i_in_valid && !o_in_stall;
    assign off_grid = (32'(i_grid_row) >= ROW_COUNT) || (32'(i_grid_column) >= COLUMN_COUNT);

    // A held result beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_change_event) && $stable(o_debounced_level))
        else $error("stalled result beat changed");

    // Reset empties the pipe.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A beat accepted without a following stall passes stage 1 and comes out valid.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept ##1 !o_in_stall |=> o_out_valid)
        else $error("accepted beat lost in pipe");

    // A button outside the grid gives no event and a released level.
    a_off_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && off_grid) ##1 !o_in_stall |=>
            o_out_valid && !o_change_event && !o_debounced_level)
        else $error("off-grid beat produced a nonzero result");

    // A fresh press on the grid always leaves the button pressed.
    a_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !off_grid && i_raw_level && !i_previous_level) ##1 !o_in_stall |=>
            o_out_valid && o_debounced_level)
        else $error("fresh press not reported as pressed");

endmodule

bind button_grid_release_debouncer bgrd_checker #(
    .ROW_COUNT   (ROW_COUNT),
    .COLUMN_COUNT(COLUMN_COUNT)
) u_bgrd_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for button_grid_release_debouncer
// A short table of directed scans is followed by random scan sequences that
// mostly follow each button's own history. Every accepted beat is run through
// a local model of the debouncer. Each result beat is compared with the
// oldest pending expectation. The release count is changed between phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int GRID_ROWS    = 32;
    localparam int GRID_COLS    = 8;
    localparam int GRID_SIZE    = GRID_ROWS * GRID_COLS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    typedef struct packed {
        logic [4:0] row;
        logic [2:0] col;
        logic       raw;
        logic       prev;
        logic       typed;
        logic       ev;
        logic       lvl;
    } scan_row_t;

    typedef struct packed {
        logic [7:0] pos;
        logic       ev;
        logic       lvl;
    } level_result_t;

    logic           i_clk             = 1'b0;
    logic           i_rst_n           = 1'b0;
    logic           i_cfg_we          = 1'b0;
    bgrd_pkg::t_cfg i_cfg_data        = '0;
    logic           i_in_valid        = 1'b0;
    logic           o_in_stall;
    logic [4:0]     i_grid_row        = '0;
    logic [2:0]     i_grid_column     = '0;
    logic           i_raw_level       = 1'b0;
    logic           i_previous_level  = 1'b0;
    logic           o_out_valid;
    logic           i_out_stall       = 1'b0;
    logic           o_change_event;
    logic           o_debounced_level;

    // Local copy of the debouncer state.
    logic           settled_q [GRID_SIZE];
    logic [7:0]     counter_q [GRID_SIZE];
    bgrd_pkg::t_cfg release_count_q;

    // Last raw level sent per button, so random scans can follow history.
    logic           scan_raw [GRID_SIZE];

    level_result_t  expected_levels [$];
    int             error_count  = 0;
    int             cycle_count  = 0;
    int             burst_left   = 0;
    int             stall_run    = 0;
    stall_mode_t    stall_mode   = STALL_NONE;

    // Directed scans, run with the release count at its reset value.
    scan_row_t scan_table [24] = '{
        '{5'd0,  3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{5'd31, 3'd7, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
        '{5'd31, 3'd7, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
        '{5'd31, 3'd7, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
        '{5'd31, 3'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd31, 3'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd31, 3'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd31, 3'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd31, 3'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd31, 3'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd31, 3'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd31, 3'd7, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0},
        '{5'd0,  3'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{5'd0,  3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{5'd21, 3'd2, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
        '{5'd21, 3'd2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{5'd21, 3'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd21, 3'd2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{5'd21, 3'd2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{5'd10, 3'd5, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
        '{5'd10, 3'd5, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{5'd10, 3'd5, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{5'd31, 3'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
        '{5'd0,  3'd7, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1}
    };

    button_grid_release_debouncer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_grid_row        (i_grid_row),
        .i_grid_column     (i_grid_column),
        .i_raw_level       (i_raw_level),
        .i_previous_level  (i_previous_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_change_event    (o_change_event),
        .o_debounced_level (o_debounced_level)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    // One debouncer update on the local state; returns the result beat.
    function automatic level_result_t predict_debounce(input logic [4:0] row,
                                                       input logic [2:0] col,
                                                       input logic raw,
                                                       input logic prev);
        level_result_t r;
        int            pos;
        logic          fresh;
        logic          differs;
        r = '0;
        if (row >= GRID_ROWS || col >= GRID_COLS) begin
            return r;
        end
        pos     = row * GRID_COLS + col;
        r.pos   = pos[7:0];
        fresh   = (raw != prev);
        differs = (raw != settled_q[pos]);
        if (fresh && differs) begin
            if (raw) begin
                settled_q[pos] = 1'b1;
                r.ev = 1'b1;
            end else begin
                counter_q[pos] = release_count_q;
            end
        end else if (!fresh && differs && counter_q[pos] != 8'd0) begin
            counter_q[pos] = counter_q[pos] - 8'd1;
            if (counter_q[pos] == 8'd0) begin
                settled_q[pos] = raw;
                r.ev = 1'b1;
            end
        end
        r.lvl = settled_q[pos];
        return r;
    endfunction

    // Sends one beat, predicts its result at the accepting edge, then maybe
    // closes the burst with a gap.
    task automatic send_beat(input logic [4:0] row, input logic [2:0] col,
                             input logic raw, input logic prev,
                             input logic typed, input logic ev, input logic lvl);
        level_result_t r;
        int            gap;
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_grid_row       <= row;
        i_grid_column    <= col;
        i_raw_level      <= raw;
        i_previous_level <= prev;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = predict_debounce(row, col, raw, prev);
        if (typed) begin
            r.ev  = ev;
            r.lvl = lvl;
        end
        expected_levels.push_back(r);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_release_count(input bgrd_pkg::t_cfg value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        release_count_q = value;
    endtask

    // Random scans, mostly on a few focus buttons and mostly consistent with
    // each button's history. Toggle odds are per mille so that long counts
    // can run out. Each phase opens with a press and release per focus button.
    task automatic run_scan_phase(input int beats, input int focus_count,
                                  input int toggle_pm, input int prev_ok_pct);
        int   focus [];
        int   pos;
        logic raw;
        logic prev;
        focus = new[focus_count];
        foreach (focus[i]) begin
            focus[i] = $urandom_range(0, GRID_SIZE - 1);
            pos = focus[i];
            send_beat(pos[7:3], pos[2:0], 1'b1, scan_raw[pos], 1'b0, 1'b0, 1'b0);
            send_beat(pos[7:3], pos[2:0], 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
            scan_raw[pos] = 1'b0;
        end
        repeat (beats) begin
            if ($urandom_range(0, 99) < 85) begin
                pos = focus[$urandom_range(0, focus_count - 1)];
            end else begin
                pos = $urandom_range(0, GRID_SIZE - 1);
            end
            raw  = ($urandom_range(0, 999) < toggle_pm) ? ~scan_raw[pos] : scan_raw[pos];
            prev = ($urandom_range(0, 99) < prev_ok_pct) ? scan_raw[pos]
                                                         : 1'($urandom_range(0, 1));
            scan_raw[pos] = raw;
            send_beat(pos[7:3], pos[2:0], raw, prev, 1'b0, 1'b0, 1'b0);
            if ($urandom_range(0, 149) == 0) wait_drained();
        end
    endtask

    // Receiver back-pressure: runs of different stall patterns.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_run  = $urandom_range(16, 200);
        end
        stall_run--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ~i_out_stall;
        endcase
    end

    always @(posedge i_clk) begin
        level_result_t r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                r = expected_levels.pop_front();
                if (o_change_event !== r.ev) begin
                    report_mismatch($sformatf("button %0d change_event %b, expected %b",
                                              r.pos, o_change_event, r.ev));
                end
                if (o_debounced_level !== r.lvl) begin
                    report_mismatch($sformatf("button %0d debounced_level %b, expected %b",
                                              r.pos, o_debounced_level, r.lvl));
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < GRID_SIZE; i++) begin
            settled_q[i] = 1'b0;
            counter_q[i] = 8'd0;
            scan_raw[i]  = 1'b0;
        end
        release_count_q = bgrd_pkg::CFG_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (scan_table[i]) begin
            send_beat(scan_table[i].row, scan_table[i].col, scan_table[i].raw,
                      scan_table[i].prev, scan_table[i].typed, scan_table[i].ev,
                      scan_table[i].lvl);
            scan_raw[{scan_table[i].row, scan_table[i].col}] = scan_table[i].raw;
        end

        write_release_count(8'd3);
        run_scan_phase(300, 6, 150, 90);
        write_release_count(8'd1);
        run_scan_phase(200, 8, 300, 90);
        write_release_count(8'd255);
        run_scan_phase(350, 1, 2, 97);
        // With a zero count a release that starts now can never be accepted.
        write_release_count(8'd0);
        run_scan_phase(150, 4, 200, 90);
        write_release_count(8'd8);
        run_scan_phase(120, 32, 100, 85);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
